// ===== sv/arp_cache_with_aging_top_assert.svh =====
// Assertion macros shared by the ARP cache RTL.
`ifndef ARP_CACHE_WITH_AGING_TOP_ASSERT_SVH
`define ARP_CACHE_WITH_AGING_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ARPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/arpc_pkg.sv =====
package arpc_pkg;

	// Field widths
	localparam int REQ_W   = 2;
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int TIME_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Table size default
	localparam int ENTRIES_DEF = 64;

	// Lifetime register reset value
	localparam logic [TIME_W-1:0] LIFETIME_RESET = TIME_W'(300);

	// Sweep count saturates here
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Request kinds
	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
	localparam logic [REQ_W-1:0] REQ_SWEEP  = 2'd3;

	// Add status codes
	localparam logic [STAT_W-1:0] ST_REJECTED = 2'd0;
	localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
	localparam logic [STAT_W-1:0] ST_REPLACED = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

	// One table slot as stored in memory
	typedef struct packed {
		logic              valid;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] learned;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== sv/arpc_if.sv =====
// Request channel
interface arpc_req_if;
	import arpc_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [IP_W-1:0]   ip_addr;
	logic [MAC_W-1:0]  mac_addr;
	logic [TIME_W-1:0] time_now;

	modport source (output valid, output req_type, output ip_addr, output mac_addr,
		output time_now, input ready);
	modport sink (input valid, input req_type, input ip_addr, input mac_addr,
		input time_now, output ready);
endinterface

// Response channel
interface arpc_rsp_if;
	import arpc_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic               hit;
	logic [MAC_W-1:0]   mac_out;
	logic [COUNT_W-1:0] removed_count;

	modport source (output valid, output status, output hit, output mac_out,
		output removed_count, input ready);
	modport sink (input valid, input status, input hit, input mac_out,
		input removed_count, output ready);
endinterface

// Lifetime register write channel
interface arpc_cfg_if;
	import arpc_pkg::*;

	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/arp_cache_with_aging_top.sv =====
// Requests are served one at a time: a new request is accepted only when idle,
// once the previous response has been loaded. Each request scans all slots
// through one memory read port and one shared compare/age unit, one slot a cycle.
// Reset (arst_n low, asynchronous) sets the lifetime to 300 and then runs a
// clearing pass over all ENTRIES slots of the slot memory; requests wait for it,
// lifetime writes are taken throughout.
module arp_cache_with_aging_top #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	arpc_req_if.sink   req,
	arpc_rsp_if.source rsp,
	arpc_cfg_if.sink   cfg
);
	import arpc_pkg::*;

	`include "arp_cache_with_aging_top_assert.svh"

	localparam int AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	localparam logic [1:0] S_CLEAR  = 2'd0;
	localparam logic [1:0] S_IDLE   = 2'd1;
	localparam logic [1:0] S_SCAN   = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	// Address filters for add
	function automatic logic ip_ok(input logic [IP_W-1:0] ip);
		return (ip != '0) && (ip != '1) && (ip[IP_W-1 -: 4] != 4'hE);
	endfunction

	function automatic logic mac_ok(input logic [MAC_W-1:0] mac);
		return (mac != '0) && !mac[40];
	endfunction

	logic [1:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      iss_q;
	logic               iss_done_q;
	logic               ev_vld_q;
	logic [AW-1:0]      ev_idx_q;
	logic [TIME_W-1:0]  life_q;

	logic [REQ_W-1:0]   type_q;
	logic [IP_W-1:0]    ip_q;
	logic [MAC_W-1:0]   mac_q;
	logic [TIME_W-1:0]  now_q;

	logic               found_q;
	logic [AW-1:0]      found_idx_q;
	logic [MAC_W-1:0]   found_mac_q;
	logic               found_aged_q;
	logic               free_q;
	logic [AW-1:0]      free_idx_q;
	logic [COUNT_W-1:0] count_q;

	logic               rsp_valid_q;
	logic [STAT_W-1:0]  rsp_status_q;
	logic               rsp_hit_q;
	logic [MAC_W-1:0]   rsp_mac_q;
	logic [COUNT_W-1:0] rsp_count_q;

	logic               rd_en;
	slot_t              rd_slot;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	slot_t              wr_slot;

	logic [TIME_W:0]    age_diff;
	logic               aged;
	logic               match;
	logic               out_load;
	logic               add_ok;

	logic [STAT_W-1:0]  res_status;
	logic               res_hit;
	logic [MAC_W-1:0]   res_mac;

	// Slot memory
	arpc_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(ENTRIES)
	) u_slots (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_slot),
		.rd_en  (rd_en),
		.rd_addr(iss_q),
		.rd_data(rd_slot)
	);

	// Handshakes
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.hit = rsp_hit_q;
	assign rsp.mac_out = rsp_mac_q;
	assign rsp.removed_count = rsp_count_q;

	// Lifetime register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= LIFETIME_RESET;
		end else if (cfg.valid) begin
			life_q <= cfg.data;
		end
	end

	// Shared compare and age unit, applied to the slot read last cycle
	assign age_diff = {1'b0, now_q} - {1'b0, rd_slot.learned};
	assign aged = !age_diff[TIME_W] && (age_diff[TIME_W-1:0] >= life_q);
	assign match = rd_slot.valid && (rd_slot.ip == ip_q);

	assign rd_en = (state_q == S_SCAN) && !iss_done_q;
	assign out_load = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);
	assign add_ok = ip_ok(ip_q) && mac_ok(mac_q);

	// Sequencer: clear pass, idle, scan, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			iss_q <= '0;
			iss_done_q <= 1'b0;
			ev_vld_q <= 1'b0;
			ev_idx_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			count_q <= '0;
		end else begin
			ev_vld_q <= rd_en;
			ev_idx_q <= iss_q;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						iss_q <= '0;
						iss_done_q <= 1'b0;
						found_q <= 1'b0;
						free_q <= 1'b0;
						count_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						iss_q <= iss_q + AW'(1);
						if (iss_q == LAST) begin
							iss_done_q <= 1'b1;
						end
					end
					if (ev_vld_q) begin
						if (match && !found_q) begin
							found_q <= 1'b1;
						end
						if (!rd_slot.valid && !free_q) begin
							free_q <= 1'b1;
						end
						if (type_q == REQ_SWEEP && rd_slot.valid && aged &&
								count_q != COUNT_MAX) begin
							count_q <= count_q + COUNT_W'(1);
						end
						if (ev_idx_q == LAST) begin
							state_q <= S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// Latch the request and the slot details found during the scan
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_q <= req.req_type;
			ip_q <= req.ip_addr;
			mac_q <= req.mac_addr;
			now_q <= req.time_now;
		end
		if (state_q == S_SCAN && ev_vld_q) begin
			if (match && !found_q) begin
				found_idx_q <= ev_idx_q;
				found_mac_q <= rd_slot.mac;
				found_aged_q <= aged;
			end
			if (!rd_slot.valid && !free_q) begin
				free_idx_q <= ev_idx_q;
			end
		end
	end

	// Memory writes: clear pass, sweep deletes, final update
	always_comb begin
		wr_en = 1'b0;
		wr_addr = '0;
		wr_slot = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
			end
			S_SCAN: begin
				if (ev_vld_q && type_q == REQ_SWEEP && rd_slot.valid && aged) begin
					wr_en = 1'b1;
					wr_addr = ev_idx_q;
					wr_slot = rd_slot;
					wr_slot.valid = 1'b0;
				end
			end
			S_FINISH: begin
				if (out_load && type_q == REQ_ADD && add_ok && (found_q || free_q)) begin
					wr_en = 1'b1;
					wr_addr = found_q ? found_idx_q : free_idx_q;
					wr_slot.valid = 1'b1;
					wr_slot.ip = ip_q;
					wr_slot.mac = mac_q;
					wr_slot.learned = now_q;
				end else if (out_load && type_q == REQ_REMOVE && found_q) begin
					wr_en = 1'b1;
					wr_addr = found_idx_q;
				end
			end
			default: wr_en = 1'b0;
		endcase
	end

	// Build the response
	always_comb begin
		res_status = ST_REJECTED;
		res_hit = 1'b0;
		res_mac = '0;
		case (type_q)
			REQ_ADD: begin
				if (!add_ok) begin
					res_status = ST_REJECTED;
				end else if (found_q) begin
					res_status = ST_REPLACED;
				end else if (free_q) begin
					res_status = ST_INSERTED;
				end else begin
					res_status = ST_FULL;
				end
			end
			REQ_LOOKUP: begin
				res_hit = found_q && !found_aged_q;
				res_mac = res_hit ? found_mac_q : '0;
			end
			REQ_REMOVE: begin
				res_hit = found_q;
			end
			default: res_hit = 1'b0;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_status_q <= res_status;
			rsp_hit_q <= res_hit;
			rsp_mac_q <= res_mac;
			rsp_count_q <= (type_q == REQ_SWEEP) ? count_q : '0;
		end
	end

	// Checks
	`ARPC_ASSERT_NEXT(a_accept_scan, clk, arst_n, req.valid && req.ready, state_q == S_SCAN, "accepted item did not start a scan")
	`ARPC_ASSERT_SAME(a_eval_in_scan, clk, arst_n, ev_vld_q, state_q == S_SCAN, "slot evaluated outside a scan")
	`ARPC_ASSERT_SAME(a_scan_write, clk, arst_n, state_q == S_SCAN && wr_en, type_q == REQ_SWEEP, "memory write during a non-sweep scan")
	`ARPC_ASSERT_SAME(a_finish_after_last, clk, arst_n, state_q == S_FINISH && $past(state_q) == S_SCAN, $past(ev_vld_q) && $past(ev_idx_q) == LAST, "scan ended before the last slot")

endmodule

// ===== sv/arpc_ram.sv =====
module arpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== verif/tb_arp_cache_with_aging_top.sv =====
module tb_arp_cache_with_aging_top;
	timeunit 1ns;
	timeprecision 1ps;

	import arpc_pkg::*;

	localparam int ENTRIES       = ENTRIES_DEF;
	localparam int MAC_GROUP_BIT = 40;
	localparam int QUIET_LIMIT   = 4000;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic [TIME_W-1:0] now;
	} arp_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic               hit;
		logic [MAC_W-1:0]   mac;
		logic [COUNT_W-1:0] count;
	} arp_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	arpc_req_if req_bus();
	arpc_rsp_if rsp_bus();
	arpc_cfg_if cfg_bus();

	arp_cache_with_aging_top #(.ENTRIES(ENTRIES)) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus),
		.cfg   (cfg_bus)
	);

	// Shadow copy of the table and the lifetime register
	logic [TIME_W-1:0] lifetime;
	logic              tbl_valid   [ENTRIES];
	logic [IP_W-1:0]   tbl_ip      [ENTRIES];
	logic [MAC_W-1:0]  tbl_mac     [ENTRIES];
	logic [TIME_W-1:0] tbl_learned [ENTRIES];

	arp_req_t          request_q[$];
	arp_answer_t       answer_q[$];
	logic [IP_W-1:0]   ip_pool[$];
	logic [TIME_W-1:0] tick;
	int                errors = 0;
	int                quiet_cycles = 0;
	int                burst_left = 1;
	int                gap_left = 0;
	logic [15:0]       ready_pat = '1;
	int                pat_pos = 0;

	always #5 clk = ~clk;

	function automatic logic ip_routable(logic [IP_W-1:0] ip);
		return !(ip == '0 || ip == '1 || ip[IP_W-1 -: 4] == 4'hE);
	endfunction

	function automatic logic entry_expired(int slot, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] age;
		age = now - tbl_learned[slot];
		return now >= tbl_learned[slot] && age >= lifetime;
	endfunction

	function automatic int find_entry(logic [IP_W-1:0] ip);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_ip[i] == ip)
				return i;
		return -1;
	endfunction

	// Apply one request to the shadow table and return its answer
	function automatic arp_answer_t resolve_request(arp_req_t rq);
		arp_answer_t ans;
		int slot;
		ans = '0;
		slot = find_entry(rq.ip);
		case (rq.kind)
		REQ_ADD: begin
			if (!ip_routable(rq.ip) || rq.mac == '0 || rq.mac[MAC_GROUP_BIT]) begin
				ans.status = ST_REJECTED;
			end else begin
				if (slot >= 0) begin
					ans.status = ST_REPLACED;
				end else begin
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!tbl_valid[i])
							slot = i;
					ans.status = (slot >= 0) ? ST_INSERTED : ST_FULL;
				end
				if (slot >= 0) begin
					tbl_valid[slot]   = 1'b1;
					tbl_ip[slot]      = rq.ip;
					tbl_mac[slot]     = rq.mac;
					tbl_learned[slot] = rq.now;
				end
			end
		end
		REQ_LOOKUP: begin
			if (slot >= 0 && !entry_expired(slot, rq.now)) begin
				ans.hit = 1'b1;
				ans.mac = tbl_mac[slot];
			end
		end
		REQ_REMOVE: begin
			if (slot >= 0) begin
				tbl_valid[slot] = 1'b0;
				ans.hit = 1'b1;
			end
		end
		REQ_SWEEP: begin
			for (int i = 0; i < ENTRIES; i++)
				if (tbl_valid[i] && entry_expired(i, rq.now)) begin
					tbl_valid[i] = 1'b0;
					if (ans.count != COUNT_MAX)
						ans.count = ans.count + 1'b1;
				end
		end
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic push_req(input logic [REQ_W-1:0] kind, input logic [IP_W-1:0] ip,
		input logic [MAC_W-1:0] mac, input logic [TIME_W-1:0] now);
		arp_req_t rq;
		rq.kind = kind;
		rq.ip   = ip;
		rq.mac  = mac;
		rq.now  = now;
		request_q.push_back(rq);
	endtask

	function automatic logic [MAC_W-1:0] random_mac();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [MAC_W-1:0] unicast_mac();
		logic [MAC_W-1:0] m;
		m = random_mac();
		m[MAC_GROUP_BIT] = 1'b0;
		if (m == '0)
			m[0] = 1'b1;
		return m;
	endfunction

	function automatic void fill_pool(int n);
		logic [IP_W-1:0] ip;
		ip_pool.delete();
		repeat (n) begin
			do ip = $urandom; while (!ip_routable(ip));
			ip_pool.push_back(ip);
		end
	endfunction

	// Advance the running time mostly, with odd jumps and times in the past
	function automatic logic [TIME_W-1:0] pick_time(int step_max);
		int roll;
		roll = $urandom_range(0, 15);
		if (roll == 0)
			return $urandom;
		if (roll == 1)
			return tick - TIME_W'($urandom_range(1, 50));
		tick = tick + TIME_W'($urandom_range(0, step_max));
		return tick;
	endfunction

	task automatic queue_random(input int count, input int add_pct, input int step_max);
		arp_req_t rq;
		int roll;
		repeat (count) begin
			roll = $urandom_range(0, 99);
			rq.now = pick_time(step_max);
			if ($urandom_range(0, 9) == 0)
				rq.ip = $urandom;
			else
				rq.ip = ip_pool[$urandom_range(0, ip_pool.size() - 1)];
			rq.mac = ($urandom_range(0, 9) == 0) ? random_mac() : unicast_mac();
			if (roll < add_pct)
				rq.kind = REQ_ADD;
			else if (roll < add_pct + (100 - add_pct) * 6 / 10)
				rq.kind = REQ_LOOKUP;
			else if (roll < add_pct + (100 - add_pct) * 85 / 100)
				rq.kind = REQ_REMOVE;
			else
				rq.kind = REQ_SWEEP;
			request_q.push_back(rq);
		end
	endtask

	// Hold until every queued item went in and every answer came back
	task automatic drain();
		while (request_q.size() != 0 || req_bus.valid || answer_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_lifetime(input logic [TIME_W-1:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		lifetime = value;
	endtask

	// Request driver: bursts of items separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				answer_q.push_back(resolve_request(request_q.pop_front()));
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 6);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				end
			end
			if (!(req_bus.valid && !req_bus.ready)) begin
				if (gap_left == 0 && request_q.size() > 0) begin
					req_bus.valid    <= 1'b1;
					req_bus.req_type <= request_q[0].kind;
					req_bus.ip_addr  <= request_q[0].ip;
					req_bus.mac_addr <= request_q[0].mac;
					req_bus.time_now <= request_q[0].now;
				end else begin
					req_bus.valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// Response monitor: check each item against the oldest answer, stall on a pattern
	always @(posedge clk) begin
		arp_answer_t want;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("response item with nothing expected");
				end else begin
					want = answer_q.pop_front();
					if (rsp_bus.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							rsp_bus.status, want.status));
					if (rsp_bus.hit !== want.hit)
						report_mismatch($sformatf("hit got %0b want %0b",
							rsp_bus.hit, want.hit));
					if (rsp_bus.mac_out !== want.mac)
						report_mismatch($sformatf("mac_out got %h want %h",
							rsp_bus.mac_out, want.mac));
					if (rsp_bus.removed_count !== want.count)
						report_mismatch($sformatf("removed_count got %0d want %0d",
							rsp_bus.removed_count, want.count));
				end
			end
			rsp_bus.ready <= ready_pat[pat_pos];
			if (pat_pos == 15) begin
				pat_pos = 0;
				ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
					(16'($urandom) | 16'($urandom));
			end else begin
				pat_pos++;
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
			|| (cfg_bus.valid && cfg_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [TIME_W-1:0] life;
		req_bus.valid    = 1'b0;
		req_bus.req_type = REQ_ADD;
		req_bus.ip_addr  = '0;
		req_bus.mac_addr = '0;
		req_bus.time_now = '0;
		rsp_bus.ready    = 1'b0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.data     = '0;
		lifetime = LIFETIME_RESET;
		foreach (tbl_valid[i])
			tbl_valid[i] = 1'b0;
		tick = 2000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset lifetime
		push_req(REQ_ADD,    32'h00000000, 48'h020000000001, 1000); // unspecified address
		push_req(REQ_ADD,    32'hE0000000, 48'h020000000001, 1000); // multicast low edge
		push_req(REQ_ADD,    32'hEFFFFFFF, 48'h020000000001, 1000); // multicast high edge
		push_req(REQ_ADD,    32'hFFFFFFFF, 48'h020000000001, 1000); // broadcast
		push_req(REQ_ADD,    32'h0A000001, 48'h000000000000, 1000); // zero MAC
		push_req(REQ_ADD,    32'h0A000001, 48'h01005E000001, 1000); // group MAC
		push_req(REQ_ADD,    32'h0A000001, 48'h020000000001, 1000);
		push_req(REQ_ADD,    32'hDFFFFFFF, 48'hFEFFFFFFFFFF, 1000);
		push_req(REQ_ADD,    32'hF0000000, 48'h000000000001, 1000);
		push_req(REQ_ADD,    32'h00000001, 48'h0A0B0C0D0E0F, 1000);
		push_req(REQ_LOOKUP, 32'h0A000001, 48'hFFFFFFFFFFFF, 1299); // one tick before expiry
		push_req(REQ_LOOKUP, 32'h0A000001, 48'h000000000000, 1300); // expired, entry stays
		push_req(REQ_ADD,    32'h0A000001, 48'h020000000002, 1300); // replace expired entry
		push_req(REQ_LOOKUP, 32'h0A000001, 48'h000000000000, 999);  // time before learned
		push_req(REQ_LOOKUP, 32'hC0A80101, 48'h000000000000, 1300);
		push_req(REQ_REMOVE, 32'h0A000001, 48'h000000000000, 1300);
		push_req(REQ_REMOVE, 32'h0A000001, 48'h000000000000, 1300);
		push_req(REQ_LOOKUP, 32'h00000001, 48'h000000000000, 5000);
		push_req(REQ_REMOVE, 32'h00000001, 48'h000000000000, 5000); // remove expired entry
		push_req(REQ_SWEEP,  32'h00000000, 48'h000000000000, 1299);
		push_req(REQ_ADD,    32'h0A000001, 48'h7C0000000003, 32'hFFFFFFF0);
		push_req(REQ_SWEEP,  32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF);
		push_req(REQ_LOOKUP, 32'h0A000001, 48'h000000000000, 0);
		push_req(REQ_SWEEP,  32'h00000000, 48'h000000000000, 0);
		push_req(REQ_REMOVE, 32'hFFFFFFFF, 48'h000000000000, 0);
		drain();

		// Shortest nonzero lifetime, few addresses
		write_lifetime(1);
		fill_pool(12);
		queue_random(120, 40, 2);
		drain();

		// Zero lifetime: anything at or after its learned time is expired
		write_lifetime(0);
		push_req(REQ_ADD,    32'h0A000063, 48'h020000000063, tick);
		push_req(REQ_LOOKUP, 32'h0A000063, 48'h000000000000, tick);
		push_req(REQ_LOOKUP, 32'h0A000063, 48'h000000000000, tick - 1);
		fill_pool(10);
		queue_random(60, 40, 1);
		drain();

		// Longest lifetime with a wide pool: fill the table until it refuses
		write_lifetime('1);
		fill_pool(72);
		queue_random(220, 75, 1000);
		drain();

		write_lifetime(LIFETIME_RESET);
		fill_pool(24);
		queue_random(200, 40, 60);
		drain();

		life = $urandom_range(2, 1000);
		write_lifetime(life);
		fill_pool(40);
		queue_random(200, 45, int'(life) / 4 + 1);
		drain();

		repeat (ENTRIES + 16) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
